// ===== src/c3mc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3mc_pkg
// Shared types, constants and helpers for the 3x3 multichannel convolution.
// ----------------------------------------------------------------------------
package c3mc_pkg;

    // Default sizes handed to the top level.
    localparam int MAX_COLS_DEF     = 128;
    localparam int MAX_ROWS_DEF     = 128;
    localparam int MAX_FILTERS_DEF  = 8;
    localparam int MAX_CHANNELS_DEF = 3;
    localparam int SAMPLE_BITS_DEF  = 16;

    // Fixed geometry and field widths.
    localparam int KERNEL   = 3;
    localparam int KTAPS    = KERNEL * KERNEL;
    localparam int SUM_W    = 36;
    localparam int FID_W    = 6;
    localparam int POS_W    = 7;
    localparam int IDX_W    = 8;
    localparam int CFG_IW   = 2;
    localparam int CFG_DW   = 8;

    // Configuration register indexes.
    localparam logic [CFG_IW-1:0] REG_OUT_COLS    = 2'd0;
    localparam logic [CFG_IW-1:0] REG_OUT_ROWS    = 2'd1;
    localparam logic [CFG_IW-1:0] REG_CHANNELS    = 2'd2;
    localparam logic [CFG_IW-1:0] REG_NUM_FILTERS = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [7:0] OUT_COLS_RST    = 8'd128;
    localparam logic [7:0] OUT_ROWS_RST    = 8'd128;
    localparam logic [1:0] CHANNELS_RST    = 2'd1;
    localparam logic [3:0] NUM_FILTERS_RST = 4'd1;

    // Input item codes.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_COEFF = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_ISSUE
    } t_state;

    // One filter's partial sum travelling down the cell chain.
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [FID_W-1:0]  fid;
        logic [POS_W-1:0]  orow;
        logic [POS_W-1:0]  ocol;
        logic [SUM_W-1:0]  sum;
    } t_tok;

    // A zero register value acts as one; large values saturate.
    function automatic int lim(input int v, input int hi);
        int r;
        begin
            if (v == 0) begin
                r = 1;
            end else if (v > hi) begin
                r = hi;
            end else begin
                r = v;
            end
            return r;
        end
    endfunction

endpackage

// ===== src/c3mc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3mc_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module c3mc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/c3mc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3mc_cell
// One tap of the kernel: holds that tap's coefficient for every filter and
// adds its product to the partial sum passing through.
// ----------------------------------------------------------------------------
module c3mc_cell #(
    parameter int TAP         = 0,
    parameter int TAPS        = 27,
    parameter int MAX_FILTERS = c3mc_pkg::MAX_FILTERS_DEF,
    parameter int SAMPLE_BITS = c3mc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_coef_wr,
    input  logic [c3mc_pkg::IDX_W-1:0]    i_coef_idx,
    input  logic signed [SAMPLE_BITS-1:0] i_coef_val,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_tap_on,
    input  c3mc_pkg::t_tok                i_tok,
    output c3mc_pkg::t_tok                o_tok
);

    localparam int FW  = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
    localparam int NF  = 2 ** FW;
    localparam int PW  = (2 * SAMPLE_BITS > c3mc_pkg::SUM_W) ?
                         2 * SAMPLE_BITS : c3mc_pkg::SUM_W;
    localparam int XW  = (c3mc_pkg::IDX_W > 16) ? c3mc_pkg::IDX_W : 16;

    logic signed [SAMPLE_BITS-1:0]   r_coef [NF];
    logic signed [SAMPLE_BITS-1:0]   coef;
    logic signed [2*SAMPLE_BITS-1:0] prod;
    logic signed [PW-1:0]            prod_x;
    c3mc_pkg::t_tok                  r_tok;
    c3mc_pkg::t_tok                  n_tok;

    // Coefficient slots of this tap, one per filter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int f = 0; f < NF; f++) begin
                r_coef[f] <= '0;
            end
        end else begin
            for (int f = 0; f < MAX_FILTERS; f++) begin
                if (i_coef_wr && (XW'(i_coef_idx) == XW'(f * TAPS + TAP))) begin
                    r_coef[f] <= i_coef_val;
                end
            end
        end
    end

    // Multiply and accumulate into the passing sum.
    assign coef   = r_coef[i_tok.fid[FW-1:0]];
    assign prod   = coef * i_sample;
    assign prod_x = PW'(prod);

    always_comb begin
        n_tok = i_tok;
        if (i_tap_on) begin
            n_tok.sum = i_tok.sum + prod_x[c3mc_pkg::SUM_W-1:0];
        end
    end

    // Hand the token to the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else if (i_en) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== src/conv3x3_multichannel_stream.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3x3_multichannel_stream
// Valid 3x3 cross-correlation over one to three channels with several filters.
// ----------------------------------------------------------------------------
// Usage:
// Write the geometry registers through the cfg channel while the block is
// idle. On the input channel, op=1 beats load coefficients at slot
// filter*9*MAX_CHANNELS + channel*9 + row*3 + col; op=0 beats bring padded
// pixels in raster order with all channels side by side. For each pixel that
// completes a window, one beat per filter leaves on the output channel, filter
// order, last_of_run on the final one.
// Flow: a pixel passes the capture registers and the line store into the
// window. When it completes a window, one token per filter enters a chain of
// 9*MAX_CHANNELS tap cells, one per cycle while the output is not stalled;
// each token passes every tap cell and then the output register. The next
// input beat is taken once the chain has drained; no new pixel or
// coefficient enters while a pixel is still being processed.
// Reset clears the coefficients, the counters and the registers to their
// defaults. An output stall with a result waiting freezes the whole cell chain.
// ----------------------------------------------------------------------------
module conv3x3_multichannel_stream #(
    parameter int MAX_COLS     = c3mc_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS     = c3mc_pkg::MAX_ROWS_DEF,
    parameter int MAX_FILTERS  = c3mc_pkg::MAX_FILTERS_DEF,
    parameter int MAX_CHANNELS = c3mc_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = c3mc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [c3mc_pkg::CFG_IW-1:0]       i_cfg_index,
    input  logic [c3mc_pkg::CFG_DW-1:0]       i_cfg_data,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_op,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample_ch0,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample_ch1,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample_ch2,
    input  logic [c3mc_pkg::IDX_W-1:0]        i_coeff_index,
    input  logic signed [SAMPLE_BITS-1:0]     i_coeff_value,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [c3mc_pkg::SUM_W-1:0] o_conv_value,
    output logic [2:0]                        o_filter_id,
    output logic [c3mc_pkg::POS_W-1:0]        o_out_row,
    output logic [c3mc_pkg::POS_W-1:0]        o_out_col,
    output logic                              o_last_of_run
);

    localparam int K     = c3mc_pkg::KERNEL;
    localparam int TAPS  = c3mc_pkg::KTAPS * MAX_CHANNELS;
    localparam int LDEP  = MAX_COLS + K - 1;
    localparam int AW    = $clog2(LDEP);
    localparam int CW    = $clog2(MAX_COLS + K);
    localparam int RW    = $clog2(MAX_ROWS + K);
    localparam int FW    = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
    localparam int FCW   = $clog2(MAX_FILTERS + 1);
    localparam int CHW   = 2;
    localparam int LW    = MAX_CHANNELS * SAMPLE_BITS;

    // Configuration registers.
    logic [7:0] r_out_cols;
    logic [7:0] r_out_rows;
    logic [1:0] r_channels;
    logic [3:0] r_num_filters;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_cols    <= c3mc_pkg::OUT_COLS_RST;
            r_out_rows    <= c3mc_pkg::OUT_ROWS_RST;
            r_channels    <= c3mc_pkg::CHANNELS_RST;
            r_num_filters <= c3mc_pkg::NUM_FILTERS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                c3mc_pkg::REG_OUT_COLS:    r_out_cols    <= i_cfg_data;
                c3mc_pkg::REG_OUT_ROWS:    r_out_rows    <= i_cfg_data;
                c3mc_pkg::REG_CHANNELS:    r_channels    <= i_cfg_data[1:0];
                c3mc_pkg::REG_NUM_FILTERS: r_num_filters <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Effective geometry after clamping.
    logic [CW-1:0]  width;
    logic [RW-1:0]  height;
    logic [CHW-1:0] nch;
    logic [FCW-1:0] nf;

    assign width  = CW'(c3mc_pkg::lim(int'(r_out_cols), MAX_COLS) + K - 1);
    assign height = RW'(c3mc_pkg::lim(int'(r_out_rows), MAX_ROWS) + K - 1);
    assign nch    = CHW'(c3mc_pkg::lim(int'(r_channels), MAX_CHANNELS));
    assign nf     = FCW'(c3mc_pkg::lim(int'(r_num_filters), MAX_FILTERS));

    // Sequencer and datapath registers.
    c3mc_pkg::t_state r_state, n_state;
    logic [CW-1:0]  r_colcnt;
    logic [RW-1:0]  r_rowcnt;
    logic [CW-1:0]  r_col;
    logic [RW-1:0]  r_row;
    logic [FW-1:0]  r_fcnt;
    logic [c3mc_pkg::POS_W-1:0] r_orow, r_ocol;
    logic signed [SAMPLE_BITS-1:0] r_px  [MAX_CHANNELS];
    logic signed [SAMPLE_BITS-1:0] r_win [K][K][MAX_CHANNELS];

    logic           chain_busy;
    logic           chain_en;
    logic           in_acc;
    logic           pix_acc;
    logic           coef_wr;
    logic           has_res;
    logic           last_f;
    logic [CW-1:0]  cur_col;
    logic [RW-1:0]  row_tmp;
    logic [RW-1:0]  cur_row;
    logic [CW-1:0]  col_inc;
    logic [RW-1:0]  row_inc;
    logic           ram_we;
    logic [LW-1:0]  ram_rdata;
    logic [LW-1:0]  ram_rdata_hi;
    logic [2*LW-1:0] ram_rd_full;
    logic [LW-1:0]  ram_line0;
    logic [LW-1:0]  ram_line1;
    logic [LW-1:0]  px_flat;
    logic signed [SAMPLE_BITS-1:0] in_px [MAX_CHANNELS];

    assign in_acc  = i_in_valid && !o_in_stall;
    assign pix_acc = in_acc && (i_op == c3mc_pkg::OP_PIXEL);
    assign coef_wr = in_acc && (i_op == c3mc_pkg::OP_COEFF);

    // Gather the channel samples.
    always_comb begin
        for (int c = 0; c < MAX_CHANNELS; c++) begin
            case (c)
                0:       in_px[c] = i_sample_ch0;
                1:       in_px[c] = i_sample_ch1;
                default: in_px[c] = i_sample_ch2;
            endcase
        end
    end

    // Column and row wrap applied before a pixel is placed.
    always_comb begin
        if (r_colcnt >= width) begin
            cur_col = '0;
            row_tmp = r_rowcnt + 1'b1;
        end else begin
            cur_col = r_colcnt;
            row_tmp = r_rowcnt;
        end
        cur_row = (row_tmp >= height) ? '0 : row_tmp;
    end

    // Position advance after a pixel.
    assign col_inc = r_col + 1'b1;
    assign row_inc = r_row + 1'b1;
    assign has_res = (r_row >= RW'(K - 1)) && (r_col >= CW'(K - 1));
    assign last_f  = (FCW'(r_fcnt) == nf - 1'b1);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            c3mc_pkg::S_IDLE: begin
                if (pix_acc) begin
                    n_state = c3mc_pkg::S_LOAD;
                end
            end
            c3mc_pkg::S_LOAD: begin
                n_state = has_res ? c3mc_pkg::S_ISSUE : c3mc_pkg::S_IDLE;
            end
            c3mc_pkg::S_ISSUE: begin
                if (chain_en && last_f) begin
                    n_state = c3mc_pkg::S_IDLE;
                end
            end
            default: n_state = c3mc_pkg::S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_in_stall = 1'b1;
        ram_we     = 1'b0;
        case (r_state)
            c3mc_pkg::S_IDLE:  o_in_stall = chain_busy;
            c3mc_pkg::S_LOAD:  ram_we     = 1'b1;
            c3mc_pkg::S_ISSUE: o_in_stall = 1'b1;
            default:           o_in_stall = 1'b1;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= c3mc_pkg::S_IDLE;
            r_colcnt <= '0;
            r_rowcnt <= '0;
            r_fcnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == c3mc_pkg::S_LOAD) begin
                r_fcnt <= '0;
                if (col_inc >= width) begin
                    r_colcnt <= '0;
                    r_rowcnt <= (row_inc >= height) ? '0 : row_inc;
                end else begin
                    r_colcnt <= col_inc;
                    r_rowcnt <= r_row;
                end
            end else if (r_state == c3mc_pkg::S_ISSUE && chain_en) begin
                r_fcnt <= r_fcnt + 1'b1;
            end
        end
    end

    // Pixel capture, window shift and output position.
    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_col <= cur_col;
            r_row <= cur_row;
            for (int c = 0; c < MAX_CHANNELS; c++) begin
                r_px[c] <= in_px[c];
            end
        end
        if (r_state == c3mc_pkg::S_LOAD) begin
            r_orow <= c3mc_pkg::POS_W'(r_row - RW'(K - 1));
            r_ocol <= c3mc_pkg::POS_W'(r_col - CW'(K - 1));
            for (int r = 0; r < K; r++) begin
                for (int k = 0; k < K - 1; k++) begin
                    r_win[r][k] <= r_win[r][k + 1];
                end
            end
            for (int c = 0; c < MAX_CHANNELS; c++) begin
                r_win[0][K - 1][c] <= ram_line0[c*SAMPLE_BITS +: SAMPLE_BITS];
                r_win[1][K - 1][c] <= ram_line1[c*SAMPLE_BITS +: SAMPLE_BITS];
                r_win[2][K - 1][c] <= r_px[c];
            end
        end
    end

    // Line store: older row in the low half, newer row in the high half.
    always_comb begin
        for (int c = 0; c < MAX_CHANNELS; c++) begin
            px_flat[c*SAMPLE_BITS +: SAMPLE_BITS] = r_px[c];
        end
    end

    assign ram_line0 = ram_rdata[LW-1:0];
    assign ram_line1 = ram_rdata_hi;

    assign ram_rdata    = ram_rd_full[LW-1:0];
    assign ram_rdata_hi = ram_rd_full[2*LW-1:LW];

    c3mc_ram #(
        .WIDTH (2 * LW),
        .DEPTH (LDEP)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_col[AW-1:0]),
        .i_wdata ({px_flat, ram_line1}),
        .i_raddr (cur_col[AW-1:0]),
        .o_rdata (ram_rd_full)
    );

    // Tap chain.
    c3mc_pkg::t_tok tok [TAPS + 1];
    logic [TAPS-1:0] cell_valid;
    c3mc_pkg::t_tok r_out;
    logic           r_out_valid;

    assign chain_en = !r_out_valid || !i_out_stall;

    always_comb begin
        tok[0]       = '0;
        tok[0].valid = (r_state == c3mc_pkg::S_ISSUE);
        tok[0].last  = last_f;
        tok[0].fid   = c3mc_pkg::FID_W'(r_fcnt);
        tok[0].orow  = r_orow;
        tok[0].ocol  = r_ocol;
    end

    for (genvar t = 0; t < TAPS; t++) begin : g_cell
        localparam int CH = t / c3mc_pkg::KTAPS;
        localparam int RR = (t % c3mc_pkg::KTAPS) / K;
        localparam int KK = t % K;

        c3mc_cell #(
            .TAP         (t),
            .TAPS        (TAPS),
            .MAX_FILTERS (MAX_FILTERS),
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (chain_en),
            .i_coef_wr  (coef_wr),
            .i_coef_idx (i_coeff_index),
            .i_coef_val (i_coeff_value),
            .i_sample   (r_win[RR][KK][CH]),
            .i_tap_on   (nch > CHW'(CH)),
            .i_tok      (tok[t]),
            .o_tok      (tok[t + 1])
        );

        assign cell_valid[t] = tok[t + 1].valid;
    end

    assign chain_busy = |cell_valid;

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (chain_en) begin
            r_out_valid <= tok[TAPS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (chain_en) begin
            r_out <= tok[TAPS];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_conv_value  = r_out.sum;
    assign o_filter_id   = r_out.fid[2:0];
    assign o_out_row     = r_out.orow;
    assign o_out_col     = r_out.ocol;
    assign o_last_of_run = r_out.last;

endmodule
